### hw/rtl/dicf_pkg.sv
package dicf_pkg;

  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam logic [31:0] TAG_DISK  = 32'h4449534B;
  localparam logic [31:0] TAG_DATA  = 32'h44415441;
  localparam logic [31:0] TAG_DONE  = 32'h444F4E45;

  localparam logic [22:0] CHUNK_SIZE_RESET = 23'd512;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_DATA  = 1'b1
  } action_t;

  typedef enum logic {
    REG_TOTAL_BYTES = 1'b0,
    REG_CHUNK_SIZE  = 1'b1
  } reg_index_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### hw/rtl/disk_image_chunk_framer_crc32.sv
// disk image framer with per-chunk crc-32
//
// input channel (in_valid/in_ready): in_action 0 opens an image transfer,
// in_action 1 delivers one image byte. result channel (out_valid/out_ready)
// carries the framed stream one byte per transfer; out_last marks the final
// byte caused by an item, out_rejected flags an item that came out of order.
// registers total_bytes (address 0) and chunk_size (address 4) are written
// over the apb port, by the user only while the block is idle (unenforced).
//
// an accepted item is decoded into a frame of 1 to 17 bytes held in a shift
// buffer; its first byte is offered the cycle after acceptance. the buffer
// drains one byte per cycle while out_ready is high; a plain data byte yields
// one result byte, a chunk boundary up to 17.
// a new item is taken while the last byte of the previous frame leaves.
// a stalled receiver holds the buffer and with it the input channel.
// reset closes any transfer, empties the buffer and sets total_bytes to 0 and
// chunk_size to 512.
module disk_image_chunk_framer_crc32
  import dicf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last,
  output logic        out_rejected,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int MAX_RES = 17;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  logic [30:0] total_r;
  logic [22:0] chunk_size_r;
  logic [30:0] bytes_done_r, bytes_done_nxt;
  logic [22:0] chunk_left_r, chunk_left_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic        active_r, active_nxt;

  logic [7:0]       buf_r [MAX_RES];
  logic [7:0]       frame_nxt [MAX_RES];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rej_r, rej_nxt;

  logic        in_xfer, out_xfer, cfg_wr;
  logic [22:0] cs_eff, cl, cl_dec;
  logic [30:0] rem, done_inc;
  logic [31:0] crc_cur, crc_new, word;

  assign out_valid    = (cnt_r != '0);
  assign in_ready     = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ready);
  assign in_xfer      = in_valid && in_ready;
  assign out_xfer     = out_valid && out_ready;
  assign out_byte     = buf_r[0];
  assign out_last     = (cnt_r == CNT_W'(1));
  assign out_rejected = rej_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (reg_index_t'(paddr[2]) == REG_CHUNK_SIZE) ? {9'b0, chunk_size_r}
                                                              : {1'b0, total_r};

  assign cs_eff   = (chunk_size_r == '0) ? 23'd1 : chunk_size_r;
  assign rem      = total_r - bytes_done_r;
  assign done_inc = bytes_done_r + 31'd1;

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      frame_nxt[i] = 8'h00;
    end
    cnt_nxt        = '0;
    rej_nxt        = 1'b0;
    bytes_done_nxt = bytes_done_r;
    chunk_left_nxt = chunk_left_r;
    crc_nxt        = crc_r;
    active_nxt     = active_r;
    cl             = chunk_left_r;
    cl_dec         = '0;
    crc_cur        = crc_r;
    crc_new        = crc_r;
    word           = '0;

    if (action_t'(in_action) == ACT_START) begin
      if (active_r) begin
        rej_nxt = 1'b1;
        cnt_nxt = CNT_W'(1);
      end else begin
        word = TAG_DISK;
        for (int k = 3; k >= 0; k--) begin
          frame_nxt[cnt_nxt] = word[k*8 +: 8];
          cnt_nxt = cnt_nxt + CNT_W'(1);
        end
        word = {1'b0, total_r};
        for (int k = 3; k >= 0; k--) begin
          frame_nxt[cnt_nxt] = word[k*8 +: 8];
          cnt_nxt = cnt_nxt + CNT_W'(1);
        end
        bytes_done_nxt = '0;
        chunk_left_nxt = '0;
        crc_nxt        = CRC_INIT;
        if (total_r == '0) begin
          word = TAG_DONE;
          for (int k = 3; k >= 0; k--) begin
            frame_nxt[cnt_nxt] = word[k*8 +: 8];
            cnt_nxt = cnt_nxt + CNT_W'(1);
          end
        end else begin
          active_nxt = 1'b1;
        end
      end
    end else if (!active_r) begin
      rej_nxt = 1'b1;
      cnt_nxt = CNT_W'(1);
    end else if ((chunk_left_r == '0) && (bytes_done_r >= total_r)) begin
      active_nxt = 1'b0;
      rej_nxt    = 1'b1;
      cnt_nxt    = CNT_W'(1);
    end else begin
      if (chunk_left_r == '0) begin
        cl      = (rem < {8'b0, cs_eff}) ? rem[22:0] : cs_eff;
        crc_cur = CRC_INIT;
        word    = TAG_DATA;
        for (int k = 3; k >= 0; k--) begin
          frame_nxt[cnt_nxt] = word[k*8 +: 8];
          cnt_nxt = cnt_nxt + CNT_W'(1);
        end
        word = {9'b0, cl};
        for (int k = 3; k >= 0; k--) begin
          frame_nxt[cnt_nxt] = word[k*8 +: 8];
          cnt_nxt = cnt_nxt + CNT_W'(1);
        end
      end
      frame_nxt[cnt_nxt] = in_data_byte;
      cnt_nxt = cnt_nxt + CNT_W'(1);
      crc_new        = crc_byte(crc_cur, in_data_byte);
      cl_dec         = cl - 23'd1;
      chunk_left_nxt = cl_dec;
      bytes_done_nxt = done_inc;
      crc_nxt        = crc_new;
      if (cl_dec == '0) begin
        word = ~crc_new;
        for (int k = 3; k >= 0; k--) begin
          frame_nxt[cnt_nxt] = word[k*8 +: 8];
          cnt_nxt = cnt_nxt + CNT_W'(1);
        end
        crc_nxt = CRC_INIT;
        if (done_inc >= total_r) begin
          word = TAG_DONE;
          for (int k = 3; k >= 0; k--) begin
            frame_nxt[cnt_nxt] = word[k*8 +: 8];
            cnt_nxt = cnt_nxt + CNT_W'(1);
          end
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r      <= '0;
      chunk_size_r <= CHUNK_SIZE_RESET;
      bytes_done_r <= '0;
      chunk_left_r <= '0;
      crc_r        <= CRC_INIT;
      active_r     <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_index_t'(paddr[2]))
          REG_TOTAL_BYTES: total_r      <= pwdata[30:0];
          REG_CHUNK_SIZE:  chunk_size_r <= pwdata[22:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        bytes_done_r <= bytes_done_nxt;
        chunk_left_r <= chunk_left_nxt;
        crc_r        <= crc_nxt;
        active_r     <= active_nxt;
        cnt_r        <= cnt_nxt;
      end else if (out_xfer) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < MAX_RES; i++) begin
        buf_r[i] <= frame_nxt[i];
      end
      rej_r <= rej_nxt;
    end else if (out_xfer) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

endmodule

### tb/tb_disk_image_chunk_framer_crc32.sv
`timescale 1ns / 1ps

module tb_disk_image_chunk_framer_crc32;
  import dicf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 420;
  localparam logic [95:0] EMPTY_IMAGE = 96'h4449534B_00000000_444F4E45;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {CHK_PRED, CHK_REJECT, CHK_EMPTY_IMAGE} row_check_t;

  typedef struct {
    row_kind_t  kind;
    action_t    act;
    logic [7:0] data;
    reg_index_t idx;
    logic [31:0] value;
    row_check_t chk;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       rej;
  } stream_byte_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_last;
  logic        out_rejected;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  disk_image_chunk_framer_crc32 dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .out_last(out_last), .out_rejected(out_rejected),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // framer model state
  logic [30:0] img_total;
  logic [22:0] img_chunk;
  logic [30:0] done_cnt;
  logic [22:0] left_cnt;
  logic [31:0] chunk_crc;
  logic        xfer_open;

  logic [7:0]   frame_buf[$];
  logic         frame_rej;
  stream_byte_t expected_stream[$];
  stim_row_t    plan[$];

  int  errors;
  int  framed_items;
  int  idle_cycles;
  bit  no_idle;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic void put_word(logic [31:0] w);
    frame_buf.push_back(w[31:24]);
    frame_buf.push_back(w[23:16]);
    frame_buf.push_back(w[15:8]);
    frame_buf.push_back(w[7:0]);
  endfunction

  function automatic void frame_item(action_t a, logic [7:0] d);
    logic [22:0] cs;
    logic [30:0] rem;
    frame_buf.delete();
    frame_rej = 1'b0;
    if (a == ACT_START) begin
      if (xfer_open) begin
        frame_rej = 1'b1;
        frame_buf.push_back(8'd0);
        return;
      end
      put_word(TAG_DISK);
      put_word({1'b0, img_total});
      done_cnt = '0;
      left_cnt = '0;
      chunk_crc = CRC_INIT;
      if (img_total == 0) put_word(TAG_DONE);
      else xfer_open = 1'b1;
      return;
    end
    if (!xfer_open) begin
      frame_rej = 1'b1;
      frame_buf.push_back(8'd0);
      return;
    end
    if (left_cnt == 0) begin
      cs = (img_chunk == 0) ? 23'd1 : img_chunk;
      if (done_cnt >= img_total) begin
        xfer_open = 1'b0;
        frame_rej = 1'b1;
        frame_buf.push_back(8'd0);
        return;
      end
      rem = img_total - done_cnt;
      left_cnt = (rem < {8'd0, cs}) ? rem[22:0] : cs;
      chunk_crc = CRC_INIT;
      put_word(TAG_DATA);
      put_word({9'd0, left_cnt});
    end
    frame_buf.push_back(d);
    chunk_crc = crc_step(chunk_crc, d);
    left_cnt = left_cnt - 23'd1;
    done_cnt = done_cnt + 31'd1;
    if (left_cnt == 0) begin
      put_word(~chunk_crc);
      chunk_crc = CRC_INIT;
      if (done_cnt >= img_total) begin
        put_word(TAG_DONE);
        xfer_open = 1'b0;
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < 40) $display("mismatch %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  function automatic void add_item(action_t a, logic [7:0] d, row_check_t c);
    stim_row_t r;
    r.kind = ROW_ITEM; r.act = a; r.data = d; r.chk = c;
    r.idx = REG_TOTAL_BYTES; r.value = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_cfg(reg_index_t i, logic [31:0] v);
    stim_row_t r;
    r.kind = ROW_CFG; r.idx = i; r.value = v;
    r.act = ACT_START; r.data = '0; r.chk = CHK_PRED;
    plan.push_back(r);
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(action_t a, logic [7:0] d, row_check_t chk);
    int gap;
    stream_byte_t e;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= a;
    in_data_byte <= d;
    do @(posedge clk); while (!in_ready);
    frame_item(a, d);
    if (!frame_rej) framed_items++;
    if (chk == CHK_REJECT) begin
      e.b = 8'd0; e.last = 1'b1; e.rej = 1'b1;
      expected_stream.push_back(e);
    end else if (chk == CHK_EMPTY_IMAGE) begin
      for (int i = 0; i < 12; i++) begin
        e.b = EMPTY_IMAGE[95 - 8 * i -: 8]; e.last = (i == 11); e.rej = 1'b0;
        expected_stream.push_back(e);
      end
    end else begin
      for (int i = 0; i < frame_buf.size(); i++) begin
        e.b = frame_buf[i]; e.last = (i == frame_buf.size() - 1); e.rej = frame_rej;
        expected_stream.push_back(e);
      end
    end
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_stream.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_write(reg_index_t idx, logic [31:0] v);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_TOTAL_BYTES) img_total = v[30:0];
    else img_chunk = v[22:0];
    want = (idx == REG_TOTAL_BYTES) ? {1'b0, img_total} : {9'd0, img_chunk};
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    stream_byte_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_stream.size() == 0) begin
        report_mismatch("result with nothing expected", {24'd0, out_byte}, 32'd0);
      end else begin
        e = expected_stream.pop_front();
        if (out_byte !== e.b) report_mismatch("out_byte", {24'd0, out_byte}, {24'd0, e.b});
        if (out_last !== e.last) report_mismatch("out_last", {31'd0, out_last}, {31'd0, e.last});
        if (out_rejected !== e.rej)
          report_mismatch("out_rejected", {31'd0, out_rejected}, {31'd0, e.rej});
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      int stall;
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_START;
    in_data_byte = 8'd0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    framed_items = 0;
    no_idle = 1'b0;
    img_total = '0;
    img_chunk = CHUNK_SIZE_RESET;
    done_cnt = '0;
    left_cnt = '0;
    chunk_crc = CRC_INIT;
    xfer_open = 1'b0;

    add_item(ACT_DATA, 8'hFF, CHK_REJECT);
    add_item(ACT_START, 8'h00, CHK_EMPTY_IMAGE);
    add_cfg(REG_TOTAL_BYTES, 32'd3);
    add_cfg(REG_CHUNK_SIZE, 32'd2);
    add_item(ACT_START, 8'h00, CHK_PRED);
    add_item(ACT_START, 8'hFF, CHK_REJECT);
    add_item(ACT_DATA, 8'h00, CHK_PRED);
    add_item(ACT_DATA, 8'hFF, CHK_PRED);
    add_item(ACT_DATA, 8'hA5, CHK_PRED);
    add_item(ACT_DATA, 8'h12, CHK_REJECT);
    // zero chunk size acts as one
    add_cfg(REG_CHUNK_SIZE, 32'd0);
    add_cfg(REG_TOTAL_BYTES, 32'd2);
    add_item(ACT_START, 8'h00, CHK_PRED);
    add_item(ACT_DATA, 8'h01, CHK_PRED);
    add_item(ACT_DATA, 8'h80, CHK_PRED);
    add_cfg(REG_TOTAL_BYTES, 32'h7FFF_FFFF);
    add_cfg(REG_CHUNK_SIZE, 32'd1);
    add_item(ACT_START, 8'h00, CHK_PRED);
    add_item(ACT_DATA, 8'h5A, CHK_PRED);
    add_item(ACT_DATA, 8'h3C, CHK_PRED);
    // total shrunk under bytes done closes the transfer
    add_cfg(REG_TOTAL_BYTES, 32'd1);
    add_item(ACT_DATA, 8'h77, CHK_REJECT);
    add_item(ACT_DATA, 8'h88, CHK_REJECT);
    add_cfg(REG_CHUNK_SIZE, 32'h007F_FFFF);
    add_cfg(REG_TOTAL_BYTES, 32'd1);
    add_item(ACT_START, 8'h00, CHK_PRED);
    add_item(ACT_DATA, 8'hC3, CHK_PRED);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_drain();
        apb_write(plan[i].idx, plan[i].value);
      end else begin
        send_item(plan[i].act, plan[i].data, plan[i].chk);
      end
    end

    framed_items = 0;
    while (framed_items < RANDOM_ITEMS) begin
      int r;
      logic [31:0] v;
      wait_drain();
      no_idle = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 9);
      if (r == 0) v = 32'd0;
      else if (r == 1) v = $urandom_range(41, 120);
      else v = $urandom_range(1, 40);
      apb_write(REG_TOTAL_BYTES, v);
      r = $urandom_range(0, 9);
      if (r == 0) v = 32'd0;
      else if (r == 1) v = $urandom_range(100, 32'h7F_FFFF);
      else v = $urandom_range(1, 16);
      apb_write(REG_CHUNK_SIZE, v);
      if ($urandom_range(0, 7) == 0) send_item(ACT_DATA, 8'($urandom_range(0, 255)), CHK_PRED);
      send_item(ACT_START, 8'($urandom_range(0, 255)), CHK_PRED);
      while (xfer_open) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          send_item(ACT_START, 8'($urandom_range(0, 255)), CHK_PRED);
        end else if (r < 5) begin
          wait_drain();
          apb_write(REG_TOTAL_BYTES, $urandom_range(0, done_cnt + 8));
        end else if (r < 6) begin
          wait_drain();
          apb_write(REG_CHUNK_SIZE, $urandom_range(0, 16));
        end else begin
          send_item(ACT_DATA, 8'($urandom_range(0, 255)), CHK_PRED);
        end
      end
      if ($urandom_range(0, 5) == 0) send_item(ACT_DATA, 8'($urandom_range(0, 255)), CHK_PRED);
    end

    wait_drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_stream.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
